// File: rtl/core/ccs_pkg.sv
// Shared types, constants and helpers for the conic coefficient block.
// Used by every module under rtl/core; depends on nothing.
`default_nettype none
package ccs_pkg;

   localparam int COORD_WIDTH_DEF  = 32;
   localparam int ANGLE_WIDTH_DEF  = 16;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int QUEUE_DEPTH_DEF  = 4;
   localparam int ATAN_LEN         = 24;
   localparam int ROT_W            = 24;

   // shape kinds
   localparam logic [1:0] FUNC_CIRCLE    = 2'd0;
   localparam logic [1:0] FUNC_ELLIPSE   = 2'd1;
   localparam logic [1:0] FUNC_PARABOLA  = 2'd2;
   localparam logic [1:0] FUNC_HYPERBOLA = 2'd3;

   // parabola openings
   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_LEFT  = 2'd1;
   localparam logic [1:0] DIR_UP    = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
   localparam logic signed [63:0] ONE_Q32      = 64'sh0000_0001_0000_0000;
   localparam int                 DIV_NUM_W    = 128;

   // arctangent of 2^-i in units of 2^32 per turn
   localparam logic [31:0] ATAN_TURN [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] size_a;
      logic signed [31:0] size_b;
      logic [15:0]        rotation;
      logic [1:0]         parabola_dir;
   } req_type;

   typedef struct packed {
      logic signed [63:0] coef_a;
      logic signed [63:0] coef_b;
      logic signed [63:0] coef_c;
      logic signed [63:0] coef_d;
      logic signed [63:0] coef_e;
      logic signed [63:0] coef_f;
      logic               divide_fault;
   } rsp_type;

   // entry between front and back: finished coefficients, or the
   // operands of a rotated ellipse or hyperbola
   typedef struct packed {
      logic               quadric;
      logic               hyp;
      logic               fault;
      logic [5:0][63:0]   coef;
      logic signed [31:0] h;
      logic signed [31:0] k;
      logic signed [31:0] sa;
      logic signed [31:0] sb;
      logic signed [31:0] c;
      logic signed [31:0] s;
   } qent_type;

   function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
      logic fits;
      fits = (&v[127:63]) || !(|v[127:63]);
      if (fits) begin
         sat64 = v[63:0];
      end else if (v[127]) begin
         sat64 = {1'b1, 63'd0};
      end else begin
         sat64 = {1'b0, {63{1'b1}}};
      end
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/ccs_div.sv
// Serial restoring divider, one quotient bit per cycle, 128 by 64 bits.
// Depends on ccs_pkg.
`default_nettype none
module ccs_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [ccs_pkg::DIV_NUM_W-1:0]      num,
   input  wire logic [63:0]                        den,
   output logic                                    done,
   output logic [ccs_pkg::DIV_NUM_W-1:0]           quot
);
   import ccs_pkg::*;

   localparam int CW = $clog2(DIV_NUM_W);

   logic [DIV_NUM_W-1:0] n_ff;
   logic [63:0]          d_ff;
   logic [63:0]          rem_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [64:0]          rem_sh;
   logic                 ge;
   logic [63:0]          rem_in;

   always_comb begin
      rem_sh = {rem_ff, n_ff[DIV_NUM_W-1]};
      ge     = rem_sh >= {1'b0, d_ff};
      rem_in = ge ? 64'(rem_sh - {1'b0, d_ff}) : rem_sh[63:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            n_ff    <= num;
            d_ff    <= den;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            n_ff   <= {n_ff[DIV_NUM_W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(DIV_NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = n_ff;
endmodule
`default_nettype wire

// File: rtl/core/ccs_fifo.sv
// Short in-order queue between the front and back of the block.
// Depends on ccs_pkg for the entry type.
`default_nettype none
module ccs_fifo #(
   parameter int QUEUE_DEPTH = ccs_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ccs_pkg::qent_type push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output ccs_pkg::qent_type      head
);
   import ccs_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   qent_type      mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wp_ff;
   logic [PW-1:0] rp_ff;
   logic [NW-1:0] cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            mem_ff[wp_ff] <= push_data;
            wp_ff <= (wp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= (rp_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   assign full  = cnt_ff == NW'(QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = mem_ff[rp_ff];
endmodule
`default_nettype wire

// File: rtl/core/ccs_front.sv
// Front: accepts shapes, runs the pipelined CORDIC, finishes circles and
// parabolas, flags zero semi-axes. Depends on ccs_pkg.
`default_nettype none
module ccs_front #(
   parameter int COORD_WIDTH  = ccs_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH  = ccs_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STEPS = ccs_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ccs_pkg::req_type  req_data,
   output logic                   q_push,
   output ccs_pkg::qent_type      q_data,
   input  wire logic              q_full
);
   import ccs_pkg::*;

   typedef struct packed {
      logic [1:0]         func;
      logic [1:0]         dir;
      logic signed [31:0] h;
      logic signed [31:0] k;
      logic signed [31:0] sa;
      logic signed [31:0] sb;
      logic [1:0]         quad;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } cst_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [1:0]         dir;
      logic signed [31:0] h;
      logic signed [31:0] k;
      logic signed [31:0] sa;
      logic signed [31:0] sb;
      logic signed [31:0] c;
      logic signed [31:0] s;
      logic signed [63:0] m0;
      logic signed [63:0] m1;
      logic signed [63:0] m2;
   } pst_type;

   function automatic logic signed [31:0] sx(input logic [31:0] v);
      sx = 32'($signed(v[COORD_WIDTH-1:0]));
   endfunction

   cst_type           st_ff [CORDIC_STEPS+1];
   cst_type           st_in [CORDIC_STEPS+1];
   logic              v_ff [CORDIC_STEPS+1];
   pst_type           p_ff;
   pst_type           p_in;
   logic              pv_ff;
   qent_type          f_ff;
   qent_type          f_in;
   logic              fv_ff;
   logic              en;
   logic [ROT_W-1:0]  rot_w;
   logic [31:0]       turn;

   // the whole pipe holds while the finished entry cannot enter the queue
   assign en        = !(fv_ff && q_full);
   assign req_stall = !en;
   assign q_push    = fv_ff && !q_full;
   assign q_data    = f_ff;

   always_comb begin
      rot_w             = ROT_W'(req_data.rotation);
      turn              = 32'(rot_w[ANGLE_WIDTH-1:0]) << (32 - ANGLE_WIDTH);
      st_in[0].func     = req_data.func;
      st_in[0].dir      = req_data.parabola_dir;
      st_in[0].h        = sx(req_data.center_x);
      st_in[0].k        = sx(req_data.center_y);
      st_in[0].sa       = sx(req_data.size_a);
      st_in[0].sb       = sx(req_data.size_b);
      st_in[0].quad     = turn[31:30];
      st_in[0].x        = CORDIC_START;
      st_in[0].y        = '0;
      st_in[0].z        = $signed({4'd0, turn[29:0]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (en) begin
         v_ff[0] <= req_valid;
      end
      if (en) begin
         st_ff[0] <= st_in[0];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      always_comb begin
         st_in[i+1] = st_ff[i];
         if (!st_ff[i].z[33]) begin
            st_in[i+1].x = st_ff[i].x - (st_ff[i].y >>> i);
            st_in[i+1].y = st_ff[i].y + (st_ff[i].x >>> i);
            st_in[i+1].z = st_ff[i].z - $signed(34'(ATAN_TURN[i]));
         end else begin
            st_in[i+1].x = st_ff[i].x + (st_ff[i].y >>> i);
            st_in[i+1].y = st_ff[i].y - (st_ff[i].x >>> i);
            st_in[i+1].z = st_ff[i].z + $signed(34'(ATAN_TURN[i]));
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (en) begin
            v_ff[i+1] <= v_ff[i];
         end
         if (en) begin
            st_ff[i+1] <= st_in[i+1];
         end
      end
   end

   // quadrant fold and the products of circles and parabolas
   always_comb begin
      logic signed [31:0] u0;
      logic signed [31:0] u1;
      logic signed [31:0] u2;
      cst_type            t;
      logic               circ;
      t          = st_ff[CORDIC_STEPS];
      circ       = t.func == FUNC_CIRCLE;
      p_in.func  = t.func;
      p_in.dir   = t.dir;
      p_in.h     = t.h;
      p_in.k     = t.k;
      p_in.sa    = t.sa;
      p_in.sb    = t.sb;
      unique case (t.quad)
         2'd0: begin
            p_in.c = t.x[31:0];
            p_in.s = t.y[31:0];
         end
         2'd1: begin
            p_in.c = 32'(-t.y);
            p_in.s = t.x[31:0];
         end
         2'd2: begin
            p_in.c = 32'(-t.x);
            p_in.s = 32'(-t.y);
         end
         default: begin
            p_in.c = t.y[31:0];
            p_in.s = 32'(-t.x);
         end
      endcase
      u0 = (circ || t.dir == DIR_UP || t.dir == DIR_DOWN) ? t.h : t.k;
      u1 = circ ? t.k : t.sa;
      u2 = circ ? t.k : ((t.dir == DIR_RIGHT || t.dir == DIR_LEFT) ? t.h : t.k);
      p_in.m0 = 64'(u0) * 64'(u0);
      p_in.m1 = 64'(u1) * 64'(u2);
      p_in.m2 = 64'(t.sa) * 64'(t.sa);
   end

   always_comb begin
      logic signed [63:0]  lin;
      logic signed [63:0]  dh;
      logic signed [63:0]  dk;
      logic signed [127:0] fc;
      logic signed [127:0] fp;
      logic signed [127:0] fm;
      lin = 64'(p_ff.sa) <<< 18;
      dh  = -(64'(p_ff.h) <<< 17);
      dk  = -(64'(p_ff.k) <<< 17);
      fc  = 128'(p_ff.m0) + 128'(p_ff.m1) - 128'(p_ff.m2);
      fp  = 128'(p_ff.m0) + (128'(p_ff.m1) <<< 2);
      fm  = 128'(p_ff.m0) - (128'(p_ff.m1) <<< 2);
      f_in.quadric = 1'b0;
      f_in.hyp     = p_ff.func == FUNC_HYPERBOLA;
      f_in.fault   = 1'b0;
      f_in.coef    = '0;
      f_in.h       = p_ff.h;
      f_in.k       = p_ff.k;
      f_in.sa      = p_ff.sa;
      f_in.sb      = p_ff.sb;
      f_in.c       = p_ff.c;
      f_in.s       = p_ff.s;
      unique case (p_ff.func)
         FUNC_CIRCLE: begin
            f_in.coef[0] = ONE_Q32;
            f_in.coef[2] = ONE_Q32;
            f_in.coef[3] = dh;
            f_in.coef[4] = dk;
            f_in.coef[5] = sat64(fc);
         end
         FUNC_PARABOLA: begin
            case (p_ff.dir)
               DIR_RIGHT, DIR_LEFT: begin
                  f_in.coef[2] = ONE_Q32;
                  f_in.coef[3] = (p_ff.dir == DIR_RIGHT) ? -lin : lin;
                  f_in.coef[4] = dk;
                  f_in.coef[5] = sat64((p_ff.dir == DIR_RIGHT) ? fp : fm);
               end
               default: begin
                  f_in.coef[0] = ONE_Q32;
                  f_in.coef[3] = dh;
                  f_in.coef[4] = (p_ff.dir == DIR_UP) ? -lin : lin;
                  f_in.coef[5] = sat64((p_ff.dir == DIR_UP) ? fp : fm);
               end
            endcase
         end
         default: begin
            // zero semi-axis: zero coefficients, no work for the back
            if (p_ff.sa == '0 || p_ff.sb == '0) begin
               f_in.fault = 1'b1;
            end else begin
               f_in.quadric = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff <= 1'b0;
         fv_ff <= 1'b0;
      end else if (en) begin
         pv_ff <= v_ff[CORDIC_STEPS];
         fv_ff <= pv_ff;
      end
      if (en) begin
         p_ff <= p_in;
         f_ff <= f_in;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/ccs_back.sv
// Back: passes finished entries to the output register and works out the
// rotated ellipse and hyperbola terms with one shared multiplier and
// the serial divider. Depends on ccs_pkg and ccs_div.
`default_nettype none
module ccs_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire ccs_pkg::qent_type q_head,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ccs_pkg::rsp_type       rsp_data
);
   import ccs_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

   localparam logic [4:0] MUL_LAST  = 5'd14;
   localparam logic [4:0] DIV_FIRST = 5'd15;
   localparam logic [4:0] DIV_LAST  = 5'd26;

   state_type           state_ff;
   qent_type            ent_ff;
   logic [4:0]          step_ff;
   logic [2:0]          mph_ff;
   logic                dph_ff;
   logic [63:0]         mx_ff;
   logic [63:0]         my_ff;
   logic                mneg_ff;
   logic [63:0]         prod_ff;
   logic [1:0]          psh_ff;
   logic [127:0]        acc_ff;
   logic [63:0]         da_ff;
   logic [63:0]         db_ff;
   logic signed [63:0]  hc_ff;
   logic signed [63:0]  ks_ff;
   logic signed [63:0]  kc_ff;
   logic signed [63:0]  hs_ff;
   logic signed [63:0]  cc_ff;
   logic signed [63:0]  ss_ff;
   logic signed [63:0]  cs_ff;
   logic signed [127:0] pc_ff;
   logic signed [127:0] ps_ff;
   logic signed [127:0] qs_ff;
   logic signed [127:0] qc_ff;
   logic signed [127:0] pp_ff;
   logic signed [127:0] qq_ff;
   logic signed [127:0] coef_ff [6];
   rsp_type             rsp_ff;
   logic                rsp_valid_ff;

   logic                out_free;
   logic                rsp_load;
   logic signed [63:0]  pv;
   logic signed [63:0]  qv;
   logic signed [63:0]  opx;
   logic signed [63:0]  opy;
   logic [1:0]          pidx;
   logic [31:0]         xh;
   logic [31:0]         yh;
   logic signed [127:0] mres;
   logic [4:0]          dstep;
   logic [2:0]          cj;
   logic                use_b;
   logic signed [127:0] dx;
   logic                xneg;
   logic [127:0]        xmag;
   logic [127:0]        num;
   logic                cneg;
   logic                div_start;
   logic                div_done;
   logic [127:0]        div_q;
   logic signed [127:0] term;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty && (q_head.quadric || out_free);
   // output register takes a new transfer this cycle
   assign rsp_load  = (q_pop && !q_head.quadric) || (state_ff == ST_FIN && out_free);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pv = hc_ff + ks_ff;
   assign qv = kc_ff - hs_ff;

   // operand pair of each multiply step
   always_comb begin
      unique case (step_ff)
         5'd0:    begin opx = 64'(ent_ff.sa); opy = 64'(ent_ff.sa); end
         5'd1:    begin opx = 64'(ent_ff.sb); opy = 64'(ent_ff.sb); end
         5'd2:    begin opx = 64'(ent_ff.h);  opy = 64'(ent_ff.c);  end
         5'd3:    begin opx = 64'(ent_ff.k);  opy = 64'(ent_ff.s);  end
         5'd4:    begin opx = 64'(ent_ff.k);  opy = 64'(ent_ff.c);  end
         5'd5:    begin opx = 64'(ent_ff.h);  opy = 64'(ent_ff.s);  end
         5'd6:    begin opx = 64'(ent_ff.c);  opy = 64'(ent_ff.c);  end
         5'd7:    begin opx = 64'(ent_ff.s);  opy = 64'(ent_ff.s);  end
         5'd8:    begin opx = 64'(ent_ff.c);  opy = 64'(ent_ff.s);  end
         5'd9:    begin opx = pv;             opy = 64'(ent_ff.c);  end
         5'd10:   begin opx = pv;             opy = 64'(ent_ff.s);  end
         5'd11:   begin opx = qv;             opy = 64'(ent_ff.s);  end
         5'd12:   begin opx = qv;             opy = 64'(ent_ff.c);  end
         5'd13:   begin opx = pv;             opy = pv;             end
         default: begin opx = qv;             opy = qv;             end
      endcase
   end

   always_comb begin
      pidx = 2'(mph_ff - 3'd1);
      xh   = pidx[1] ? mx_ff[63:32] : mx_ff[31:0];
      yh   = pidx[0] ? my_ff[63:32] : my_ff[31:0];
      mres = mneg_ff ? -$signed(acc_ff) : $signed(acc_ff);
   end

   // numerator, divisor side and sign of each division step
   always_comb begin
      dstep = step_ff - DIV_FIRST;
      cj    = dstep[3:1];
      use_b = dstep[0];
      case (cj)
         3'd0:    dx = use_b ? 128'(ss_ff) : 128'(cc_ff);
         3'd1:    dx = 128'(cs_ff);
         3'd2:    dx = use_b ? 128'(cc_ff) : 128'(ss_ff);
         3'd3:    dx = use_b ? qs_ff : pc_ff;
         3'd4:    dx = use_b ? qc_ff : ps_ff;
         default: dx = use_b ? qq_ff : pp_ff;
      endcase
      xneg = dx[127];
      xmag = xneg ? 128'(-dx) : 128'(dx);
      case (cj)
         3'd0, 3'd2: num = xmag << 4;
         3'd1:       num = xmag << 5;
         3'd3, 3'd4: num = xmag >> 11;
         default:    num = xmag >> 28;
      endcase
      if (use_b) begin
         cneg = (cj == 3'd1 || cj == 3'd4) ^ ent_ff.hyp;
      end else begin
         cneg = (cj == 3'd3 || cj == 3'd4);
      end
      term      = (xneg ^ cneg) ? -$signed(div_q) : $signed(div_q);
      div_start = (state_ff == ST_DIV) && !dph_ff;
   end

   ccs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (use_b ? db_ff : da_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         mph_ff       <= '0;
         dph_ff       <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  if (q_head.quadric) begin
                     ent_ff  <= q_head;
                     step_ff <= '0;
                     mph_ff  <= '0;
                     dph_ff  <= 1'b0;
                     for (int j = 0; j < 5; j++) begin
                        coef_ff[j] <= '0;
                     end
                     coef_ff[5] <= -128'(ONE_Q32);
                     state_ff   <= ST_MUL;
                  end else begin
                     rsp_ff.coef_a       <= q_head.coef[0];
                     rsp_ff.coef_b       <= q_head.coef[1];
                     rsp_ff.coef_c       <= q_head.coef[2];
                     rsp_ff.coef_d       <= q_head.coef[3];
                     rsp_ff.coef_e       <= q_head.coef[4];
                     rsp_ff.coef_f       <= q_head.coef[5];
                     rsp_ff.divide_fault <= q_head.fault;
                     rsp_valid_ff        <= 1'b1;
                  end
               end
            end
            ST_MUL: begin
               // magnitudes, four 32x32 partials, then sign and store
               if (mph_ff == 3'd0) begin
                  mx_ff   <= opx[63] ? 64'(-opx) : 64'(opx);
                  my_ff   <= opy[63] ? 64'(-opy) : 64'(opy);
                  mneg_ff <= opx[63] ^ opy[63];
                  acc_ff  <= '0;
               end
               if (mph_ff >= 3'd1 && mph_ff <= 3'd4) begin
                  prod_ff <= 64'(xh) * 64'(yh);
                  psh_ff  <= 2'(pidx[1]) + 2'(pidx[0]);
               end
               if (mph_ff >= 3'd2 && mph_ff <= 3'd5) begin
                  acc_ff <= acc_ff + (128'(prod_ff) << {psh_ff, 5'd0});
               end
               if (mph_ff == 3'd6) begin
                  case (step_ff)
                     5'd0:    da_ff <= mres[63:0];
                     5'd1:    db_ff <= mres[63:0];
                     5'd2:    hc_ff <= mres[63:0];
                     5'd3:    ks_ff <= mres[63:0];
                     5'd4:    kc_ff <= mres[63:0];
                     5'd5:    hs_ff <= mres[63:0];
                     5'd6:    cc_ff <= mres[63:0];
                     5'd7:    ss_ff <= mres[63:0];
                     5'd8:    cs_ff <= mres[63:0];
                     5'd9:    pc_ff <= mres;
                     5'd10:   ps_ff <= mres;
                     5'd11:   qs_ff <= mres;
                     5'd12:   qc_ff <= mres;
                     5'd13:   pp_ff <= mres;
                     default: qq_ff <= mres;
                  endcase
                  mph_ff  <= '0;
                  step_ff <= step_ff + 1'b1;
                  if (step_ff == MUL_LAST) begin
                     state_ff <= ST_DIV;
                  end
               end else begin
                  mph_ff <= mph_ff + 1'b1;
               end
            end
            ST_DIV: begin
               if (!dph_ff) begin
                  dph_ff <= 1'b1;
               end else if (div_done) begin
                  coef_ff[cj] <= coef_ff[cj] + term;
                  dph_ff      <= 1'b0;
                  step_ff     <= step_ff + 1'b1;
                  if (step_ff == DIV_LAST) begin
                     state_ff <= ST_FIN;
                  end
               end
            end
            default: begin
               if (out_free) begin
                  rsp_ff.coef_a       <= sat64(coef_ff[0]);
                  rsp_ff.coef_b       <= sat64(coef_ff[1]);
                  rsp_ff.coef_c       <= sat64(coef_ff[2]);
                  rsp_ff.coef_d       <= sat64(coef_ff[3]);
                  rsp_ff.coef_e       <= sat64(coef_ff[4]);
                  rsp_ff.coef_f       <= sat64(coef_ff[5]);
                  rsp_ff.divide_fault <= 1'b0;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= ST_IDLE;
               end
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/conic_coefficients_from_shape.sv
// Top level: general conic coefficients from a shape description.
// Depends on ccs_pkg, ccs_front, ccs_fifo and ccs_back.
//
//   port group  dir  handshake              payload
//   req_*       in   req_valid/req_stall    req_type: shape, center, sizes, angle
//   rsp_*       out  rsp_valid/rsp_stall    rsp_type: six Q32.32 coefficients, fault
//
// Circles, parabolas and zero-axis faults: one item per cycle while the back is
// idle and no stall is raised; rsp_valid rises after the input and CORDIC stages,
// the product and coefficient registers, the queue and the output register. A
// rotated ellipse or hyperbola holds the back through fifteen multiplies on the
// one 32x32 multiplier and twelve divisions on the one-bit-per-cycle divider.
// The front keeps taking items into a QUEUE_DEPTH queue meanwhile.
// Synchronous reset clears all valid flags; no clearing pass.
// req_stall rises only when the queue is full and the front pipe holds.
`default_nettype none
module conic_coefficients_from_shape #(
   parameter int COORD_WIDTH  = ccs_pkg::COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH  = ccs_pkg::ANGLE_WIDTH_DEF,
   parameter int CORDIC_STEPS = ccs_pkg::CORDIC_STEPS_DEF,
   parameter int QUEUE_DEPTH  = ccs_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ccs_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ccs_pkg::rsp_type      rsp_data
);
   import ccs_pkg::*;

   logic     q_push;
   logic     q_full;
   logic     q_pop;
   logic     q_empty;
   qent_type q_in;
   qent_type q_head;

   ccs_front #(
      .COORD_WIDTH  (COORD_WIDTH),
      .ANGLE_WIDTH  (ANGLE_WIDTH),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_data    (q_in),
      .q_full    (q_full)
   );

   ccs_fifo #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   ccs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire
